// ----- hdl/ssrsg_pkg.sv -----
// shared constants, register codes and constant dividers for the spindle speed ramp
// with stall guard; no dependencies

package ssrsg_pkg;

    localparam int SSRSG_COUNT_WIDTH = 16;

    localparam int PCT_W      = 8;
    localparam int RPM_W      = 16;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int STALL_MS_W = 12;
    localparam int RAMP_W     = 4;

    // clipped speed for the stall compare, normal rpm and stall threshold widths
    localparam int SPD_CMP_W  = 18;
    localparam int NRM_W      = 18;
    localparam int MIN_W      = 17;
    localparam int DIV_IN_W   = 24;

    localparam int STALL_LIMIT_MS = 3000;
    localparam int RAMP_PERIOD_MS = 10;
    localparam int MIN_SPEED_PCT  = 60;
    localparam int FULL_PCT       = 100;

    localparam logic [PCT_W-1:0] PWM_FULL_SCALE_RST = 8'd100;
    localparam logic [RPM_W-1:0] RPM_PER_COUNT_RST  = 16'd1;
    localparam logic [RPM_W-1:0] MAX_RPM_RST        = 16'd12000;

    // divide by 100 as multiply by ceil(2^31 / 100), exact for any 24-bit value
    localparam int DIV100_SHIFT = DIV_IN_W + 7;
    localparam int DIV100_MUL_W = 25;
    localparam logic [DIV100_MUL_W-1:0] DIV100_MUL =
        DIV100_MUL_W'(((64'd1 << DIV100_SHIFT) + 64'd99) / 64'd100);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PWM_INVERT     = 2'd0,
        REG_PWM_FULL_SCALE = 2'd1,
        REG_RPM_PER_COUNT  = 2'd2,
        REG_MAX_RPM        = 2'd3
    } cfg_reg_t;

    function automatic logic [NRM_W-1:0] div100(input logic [DIV_IN_W-1:0] x);
        logic [DIV_IN_W+DIV100_MUL_W-1:0] p;
        p = {{DIV100_MUL_W{1'b0}}, x} * {{DIV_IN_W{1'b0}}, DIV100_MUL};
        return p[DIV100_SHIFT +: NRM_W];
    endfunction

    // percent times full scale over 100, saturated to a duty byte
    function automatic logic [PCT_W-1:0] duty_sat(input logic [2*PCT_W-1:0] prod);
        logic [NRM_W-1:0] q;
        q = div100(DIV_IN_W'(prod));
        return (|q[NRM_W-1:PCT_W]) ? '1 : q[PCT_W-1:0];
    endfunction

endpackage

// ----- hdl/ssrsg_ifs.sv -----
// valid/ready channel interfaces for the sample and report words
// depends on ssrsg_pkg

interface ssrsg_sample_if
    import ssrsg_pkg::*;
();
    logic             valid;
    logic             ready;
    logic             tach_rise;
    logic             gate_end;
    logic             ms_tick;
    logic             set_valid;
    logic [PCT_W-1:0] set_percent;

    modport source (output valid, tach_rise, gate_end, ms_tick, set_valid, set_percent,
                    input ready);
    modport sink   (input valid, tach_rise, gate_end, ms_tick, set_valid, set_percent,
                    output ready);
endinterface

interface ssrsg_report_if
    import ssrsg_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [PCT_W-1:0] pwm_duty;
    logic [RPM_W-1:0] speed_rpm;
    logic             speed_ok;

    modport source (output valid, pwm_duty, speed_rpm, speed_ok, input ready);
    modport sink   (input valid, pwm_duty, speed_rpm, speed_ok, output ready);
endinterface

// ----- hdl/spindle_speed_ramp_stall_guard.sv -----
// spindle speed ramp with stall guard: tach gating, ramped pwm duty, stall timeout
// depends on ssrsg_pkg and the channel interfaces in ssrsg_ifs.sv
//
//  channel      direction  handshake     word
//  sample_word  sink       valid/ready   tach_rise, gate_end, ms_tick, set_valid, set_percent
//  report_word  source     valid/ready   pwm_duty, speed_rpm, speed_ok
//  cfg_*        sink       cfg_we only   cfg_index, cfg_data
//
// one word accepted per cycle while sample_word.ready is high, one report per word; five
// registers deep (stages 1 to 4 and the report register), each word passing them in order
// the stages split the products and the chained divide-by-100 reciprocal multipliers
// rst_n clears all pipeline valids and state and restores the register defaults
// a stalled report holds only the stages behind it that are full; bubbles close up, so
// sample_word keeps accepting until every stage holds a word

module spindle_speed_ramp_stall_guard
    import ssrsg_pkg::*;
#(
    parameter int COUNT_WIDTH = SSRSG_COUNT_WIDTH
)(
    input  logic                  clk,
    input  logic                  rst_n,
    ssrsg_sample_if.sink          sample_word,
    ssrsg_report_if.source        report_word,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int SPD_W = COUNT_WIDTH + RPM_W;

    // configuration registers
    logic             pwm_invert_reg;
    logic [PCT_W-1:0] full_scale_reg;
    logic [RPM_W-1:0] rpm_per_count_reg;
    logic [RPM_W-1:0] max_rpm_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pwm_invert_reg    <= 1'b0;
            full_scale_reg    <= PWM_FULL_SCALE_RST;
            rpm_per_count_reg <= RPM_PER_COUNT_RST;
            max_rpm_reg       <= MAX_RPM_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_PWM_INVERT:     pwm_invert_reg    <= cfg_data[0];
                REG_PWM_FULL_SCALE: full_scale_reg    <= cfg_data[PCT_W-1:0];
                REG_RPM_PER_COUNT:  rpm_per_count_reg <= cfg_data[RPM_W-1:0];
                REG_MAX_RPM:        max_rpm_reg       <= cfg_data[RPM_W-1:0];
                default:            ;
            endcase
        end
    end

    // stage valids and the ready chain; each stage loads when empty or when the
    // stage after it moves on
    logic s1_v_reg, s2_v_reg, s3_v_reg, s4_v_reg, out_v_reg;
    logic adv_out, rdy4, rdy3, rdy2, rdy1;
    logic accept, ld_out;

    assign adv_out = !out_v_reg || report_word.ready;
    assign rdy4    = !s4_v_reg || adv_out;
    assign rdy3    = !s3_v_reg || rdy4;
    assign rdy2    = !s2_v_reg || rdy3;
    assign rdy1    = !s1_v_reg || rdy2;

    assign sample_word.ready = rdy1;
    assign accept            = sample_word.valid && rdy1;
    assign ld_out            = adv_out && s4_v_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg  <= 1'b0;
            s2_v_reg  <= 1'b0;
            s3_v_reg  <= 1'b0;
            s4_v_reg  <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
                s1_v_reg <= sample_word.valid;
            if (rdy2)
                s2_v_reg <= s1_v_reg;
            if (rdy3)
                s3_v_reg <= s2_v_reg;
            if (rdy4)
                s4_v_reg <= s3_v_reg;
            if (adv_out)
                out_v_reg <= s4_v_reg;
        end
    end

    // front state: command, edge counting and gate latch, updated on acceptance
    logic [COUNT_WIDTH-1:0] edge_cnt_reg, edge_cnt_next;
    logic [COUNT_WIDTH-1:0] latched_reg, latched_next;
    logic [PCT_W-1:0]       target_reg, target_next;
    logic [PCT_W-1:0]       pct_clamp;
    logic [COUNT_WIDTH-1:0] cnt_inc;

    always_comb
    begin
        pct_clamp = (sample_word.set_percent > PCT_W'(FULL_PCT)) ?
                    PCT_W'(FULL_PCT) : sample_word.set_percent;
        target_next = target_reg;
        if (sample_word.set_valid)
        begin
            if (!pwm_invert_reg)
                target_next = pct_clamp;
            else if (full_scale_reg >= pct_clamp)
                target_next = full_scale_reg - pct_clamp;
            else
                target_next = '0;
        end

        // edge counter saturates at all ones
        cnt_inc = edge_cnt_reg;
        if (sample_word.tach_rise && (edge_cnt_reg != {COUNT_WIDTH{1'b1}}))
            cnt_inc = edge_cnt_reg + 1'b1;

        if (sample_word.gate_end)
        begin
            latched_next  = cnt_inc;
            edge_cnt_next = '0;
        end
        else
        begin
            latched_next  = latched_reg;
            edge_cnt_next = cnt_inc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            edge_cnt_reg <= '0;
            latched_reg  <= '0;
            target_reg   <= '0;
        end
        else if (accept)
        begin
            edge_cnt_reg <= edge_cnt_next;
            latched_reg  <= latched_next;
            target_reg   <= target_next;
        end
    end

    // stage 1: the word's post-command target and latched count
    logic [COUNT_WIDTH-1:0] s1_lat_reg;
    logic [PCT_W-1:0]       s1_tgt_reg;
    logic                   s1_tick_reg, s1_set_reg;

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_lat_reg  <= latched_next;
            s1_tgt_reg  <= target_next;
            s1_tick_reg <= sample_word.ms_tick;
            s1_set_reg  <= sample_word.set_valid;
        end
    end

    // stage 2: raw speed, normal rpm product and target duty product
    logic [SPD_W-1:0]      s2_spd_reg;
    logic [DIV_IN_W-1:0]   s2_nrm_prod_reg;
    logic [2*PCT_W-1:0]    s2_tdut_prod_reg;
    logic [PCT_W-1:0]      s2_tgt_reg;
    logic                  s2_tick_reg, s2_set_reg;

    always_ff @(posedge clk)
    begin
        if (rdy2 && s1_v_reg)
        begin
            s2_spd_reg       <= SPD_W'(s1_lat_reg) * SPD_W'(rpm_per_count_reg);
            s2_nrm_prod_reg  <= DIV_IN_W'(max_rpm_reg) * DIV_IN_W'(s1_tgt_reg);
            s2_tdut_prod_reg <= (2*PCT_W)'(s1_tgt_reg) * (2*PCT_W)'(full_scale_reg);
            s2_tgt_reg       <= s1_tgt_reg;
            s2_tick_reg      <= s1_tick_reg;
            s2_set_reg       <= s1_set_reg;
        end
    end

    // stage 3: speed clipped above any possible threshold, normal rpm, target duty
    logic [SPD_CMP_W-1:0] s3_spd_reg;
    logic [NRM_W-1:0]     s3_nrm_reg;
    logic [PCT_W-1:0]     s3_tduty_reg;
    logic [PCT_W-1:0]     s3_tgt_reg;
    logic                 s3_tick_reg, s3_set_reg;

    always_ff @(posedge clk)
    begin
        if (rdy3 && s2_v_reg)
        begin
            s3_spd_reg   <= (|s2_spd_reg[SPD_W-1:SPD_CMP_W]) ?
                            '1 : s2_spd_reg[SPD_CMP_W-1:0];
            s3_nrm_reg   <= div100(s2_nrm_prod_reg);
            s3_tduty_reg <= duty_sat(s2_tdut_prod_reg);
            s3_tgt_reg   <= s2_tgt_reg;
            s3_tick_reg  <= s2_tick_reg;
            s3_set_reg   <= s2_set_reg;
        end
    end

    // stage 4: stall threshold, 60 percent of normal
    logic [SPD_CMP_W-1:0] s4_spd_reg;
    logic [MIN_W-1:0]     s4_min_reg;
    logic [PCT_W-1:0]     s4_tduty_reg;
    logic [PCT_W-1:0]     s4_tgt_reg;
    logic                 s4_tick_reg, s4_set_reg;
    logic [NRM_W-1:0]     min_full;

    assign min_full = div100(DIV_IN_W'(s3_nrm_reg) * DIV_IN_W'(MIN_SPEED_PCT));

    always_ff @(posedge clk)
    begin
        if (rdy4 && s3_v_reg)
        begin
            s4_spd_reg   <= s3_spd_reg;
            s4_min_reg   <= min_full[MIN_W-1:0];
            s4_tduty_reg <= s3_tduty_reg;
            s4_tgt_reg   <= s3_tgt_reg;
            s4_tick_reg  <= s3_tick_reg;
            s4_set_reg   <= s3_set_reg;
        end
    end

    // duty for one percent below the applied value, through dec_prod_reg and dec_duty_reg;
    // applied moves at most once in eleven ticks, so both settle ahead of the next step down
    logic [PCT_W-1:0]   applied_reg, applied_next;
    logic [2*PCT_W-1:0] dec_prod_reg;
    logic [PCT_W-1:0]   dec_duty_reg;

    always_ff @(posedge clk)
    begin
        dec_prod_reg <= (2*PCT_W)'(applied_reg - 1'b1) * (2*PCT_W)'(full_scale_reg);
        dec_duty_reg <= duty_sat(dec_prod_reg);
    end

    // back state: ramp and stall guard, updated as a word enters the report register
    logic [PCT_W-1:0]      pwm_reg, pwm_next;
    logic                  stall_flag_reg, stall_flag_next;
    logic [STALL_MS_W-1:0] stall_ms_reg, stall_ms_next;
    logic [RAMP_W-1:0]     ramp_ms_reg, ramp_ms_next;
    logic [RAMP_W-1:0]     ramp_inc;
    logic                  stall_cond;
    logic [RPM_W-1:0]      spd_out_reg;
    logic                  ok_reg;

    assign stall_cond = (s4_tgt_reg != '0) && (s4_spd_reg < SPD_CMP_W'(s4_min_reg));

    always_comb
    begin
        applied_next    = applied_reg;
        pwm_next        = pwm_reg;
        ramp_ms_next    = ramp_ms_reg;
        stall_flag_next = s4_set_reg ? 1'b0 : stall_flag_reg;
        stall_ms_next   = s4_set_reg ? '0 : stall_ms_reg;
        ramp_inc        = ramp_ms_reg + 1'b1;

        if (s4_tick_reg)
        begin
            // ramp step once more than the ramp period has gone by
            if (ramp_inc > RAMP_W'(RAMP_PERIOD_MS))
            begin
                ramp_ms_next = '0;
                if (s4_tgt_reg > applied_reg)
                begin
                    applied_next = s4_tgt_reg;
                    pwm_next     = s4_tduty_reg;
                end
                else if (s4_tgt_reg < applied_reg)
                begin
                    applied_next = applied_reg - 1'b1;
                    pwm_next     = dec_duty_reg;
                end
            end
            else
                ramp_ms_next = ramp_inc;

            // stall guard on every tick
            if (stall_cond)
            begin
                if (!stall_flag_next)
                begin
                    stall_flag_next = 1'b1;
                    stall_ms_next   = '0;
                end
                else if (stall_ms_next != {STALL_MS_W{1'b1}})
                    stall_ms_next = stall_ms_next + 1'b1;
                if (stall_ms_next > STALL_MS_W'(STALL_LIMIT_MS))
                    pwm_next = '0;
            end
            else
            begin
                stall_flag_next = 1'b0;
                stall_ms_next   = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            applied_reg    <= '0;
            pwm_reg        <= '0;
            stall_flag_reg <= 1'b0;
            stall_ms_reg   <= '0;
            ramp_ms_reg    <= '0;
            ok_reg         <= 1'b1;
        end
        else if (ld_out)
        begin
            applied_reg    <= applied_next;
            pwm_reg        <= pwm_next;
            stall_flag_reg <= stall_flag_next;
            stall_ms_reg   <= stall_ms_next;
            ramp_ms_reg    <= ramp_ms_next;
            ok_reg         <= !(stall_flag_next &&
                                (stall_ms_next > STALL_MS_W'(STALL_LIMIT_MS)));
        end
    end

    // reported speed saturates at 16 bits
    always_ff @(posedge clk)
    begin
        if (ld_out)
            spd_out_reg <= (|s4_spd_reg[SPD_CMP_W-1:RPM_W]) ? '1 : s4_spd_reg[RPM_W-1:0];
    end

    assign report_word.valid     = out_v_reg;
    assign report_word.pwm_duty  = pwm_reg;
    assign report_word.speed_rpm = spd_out_reg;
    assign report_word.speed_ok  = ok_reg;

    // a timed-out stall always leaves the duty forced to zero
    assert property (@(posedge clk) disable iff (!rst_n)
        !ok_reg |-> (pwm_reg == '0))
        else $error("stall timeout reported with nonzero duty");

    // the stall timer only runs while the stall flag is set
    assert property (@(posedge clk) disable iff (!rst_n)
        !stall_flag_reg |-> (stall_ms_reg == '0))
        else $error("stall timer running without stall flag");

    // the ramp timer wraps as soon as it passes the ramp period
    assert property (@(posedge clk) disable iff (!rst_n)
        ramp_ms_reg <= RAMP_W'(RAMP_PERIOD_MS))
        else $error("ramp timer beyond ramp period");

    // the applied percent moves only on a ramp step, which restarts the ramp timer
    assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(applied_reg) |-> (ramp_ms_reg == '0))
        else $error("applied percent changed outside a ramp step");

endmodule

// ----- test/testbench.sv -----
// self-checking bench for spindle_speed_ramp_stall_guard: directed words, a stall run
// that arms the guard and randomised phases checked against a cycle-free predictor
// depends on ssrsg_pkg, ssrsg_ifs.sv and the block itself
`timescale 1ns / 1ps

module testbench;

    import ssrsg_pkg::*;

    localparam int  CLK_HALF_NS   = 4;
    localparam int  RESET_CYCLES  = 10;
    localparam int  SETTLE_CYCLES = 8;        // beyond the depth of the five-stage pipe
    localparam int  HOLD_CYCLES   = 60;       // long report hold-off, well past pipe depth
    localparam int  STALL_TICKS   = 40;       // ticks under stall, counting the stall timer up
    localparam int  PHASES        = 8;
    localparam int  PHASE_WORDS   = 185;
    localparam int  PRINT_CAP     = 20;
    localparam longint LIMIT_NS   = 4_000_000;

    typedef struct packed {
        logic             tach_rise;
        logic             gate_end;
        logic             ms_tick;
        logic             set_valid;
        logic [PCT_W-1:0] set_percent;
    } sample_word_t;

    typedef struct packed {
        logic [PCT_W-1:0] pwm_duty;
        logic [RPM_W-1:0] speed_rpm;
        logic             speed_ok;
    } report_word_t;

    // scoreboard: tracks the spindle state word by word and holds the reports it implies
    class spindle_scoreboard;
        report_word_t             due_reports[$];
        // register copies
        logic                     invert;
        logic [PCT_W-1:0]         full_scale;
        logic [RPM_W-1:0]         rpm_step;
        logic [RPM_W-1:0]         rpm_top;
        // spindle state
        logic [SSRSG_COUNT_WIDTH-1:0] edges_open;
        logic [SSRSG_COUNT_WIDTH-1:0] edges_held;
        logic [PCT_W-1:0]         target;
        logic [PCT_W-1:0]         applied;
        logic [PCT_W-1:0]         duty;
        logic                     stalled;
        logic [STALL_MS_W-1:0]    stall_time;
        logic [RAMP_W-1:0]        ramp_time;
        // tallies
        int                       mismatches;
        int                       words_seen;
        int                       reports_checked;
        int                       timeout_reports;
        int                       clipped_reports;
        int                       ramp_steps;

        function new();
            invert          = 1'b0;
            full_scale      = PWM_FULL_SCALE_RST;
            rpm_step        = RPM_PER_COUNT_RST;
            rpm_top         = MAX_RPM_RST;
            edges_open      = '0;
            edges_held      = '0;
            target          = '0;
            applied         = '0;
            duty            = '0;
            stalled         = 1'b0;
            stall_time      = '0;
            ramp_time       = '0;
            mismatches      = 0;
            words_seen      = 0;
            reports_checked = 0;
            timeout_reports = 0;
            clipped_reports = 0;
            ramp_steps      = 0;
        endfunction

        function void set_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_PWM_INVERT:     invert     = data[0];
                REG_PWM_FULL_SCALE: full_scale = data[PCT_W-1:0];
                REG_RPM_PER_COUNT:  rpm_step   = data;
                REG_MAX_RPM:        rpm_top    = data;
                default:            ;
            endcase
        endfunction

        function int pending();
            return due_reports.size();
        endfunction

        // advance the spindle state by one sample word and queue its report
        function void note_sample(sample_word_t s);
            logic [PCT_W-1:0]             pct;
            logic [SSRSG_COUNT_WIDTH-1:0] cnt;
            logic [63:0]                  speed;
            logic [63:0]                  normal;
            logic [63:0]                  floor_rpm;
            logic [31:0]                  scaled;
            report_word_t                 rep;

            words_seen++;
            if (s.set_valid)
            begin
                pct = (s.set_percent > FULL_PCT) ? PCT_W'(FULL_PCT) : s.set_percent;
                if (invert)
                    pct = (full_scale >= pct) ? full_scale - pct : '0;
                target     = pct;
                stalled    = 1'b0;
                stall_time = '0;
            end

            cnt = edges_open;
            if (s.tach_rise && cnt != '1)
                cnt = cnt + 1'b1;
            if (s.gate_end)
            begin
                edges_held = cnt;
                edges_open = '0;
            end
            else
                edges_open = cnt;

            speed = 64'(edges_held) * 64'(rpm_step);
            if (s.ms_tick)
            begin
                ramp_time = ramp_time + 1'b1;
                if (ramp_time > RAMP_PERIOD_MS)
                begin
                    ramp_time = '0;
                    if (target != applied)
                    begin
                        applied = (target > applied) ? target : applied - 1'b1;
                        scaled  = (32'(applied) * 32'(full_scale)) / FULL_PCT;
                        duty    = (scaled > 255) ? 8'hFF : scaled[PCT_W-1:0];
                        ramp_steps++;
                    end
                end
                normal    = (64'(rpm_top) * 64'(target)) / FULL_PCT;
                floor_rpm = (normal * MIN_SPEED_PCT) / FULL_PCT;
                if (target != 0 && speed < floor_rpm)
                begin
                    if (!stalled)
                    begin
                        stalled    = 1'b1;
                        stall_time = '0;
                    end
                    else if (stall_time != '1)
                        stall_time = stall_time + 1'b1;
                    if (stall_time > STALL_LIMIT_MS)
                        duty = '0;
                end
                else
                begin
                    stalled    = 1'b0;
                    stall_time = '0;
                end
            end

            rep.pwm_duty  = duty;
            rep.speed_rpm = (speed > 64'hFFFF) ? '1 : speed[RPM_W-1:0];
            rep.speed_ok  = !(stalled && stall_time > STALL_LIMIT_MS);
            if (!rep.speed_ok)
                timeout_reports++;
            if (speed > 64'hFFFF)
                clipped_reports++;
            due_reports.push_back(rep);
        endfunction

        task flag_mismatch(string what, longint got, longint want);
            if (mismatches < PRINT_CAP)
                $display("mismatch at %0t: %s, got %0h, expected %0h", $realtime, what, got, want);
            mismatches++;
        endtask

        task check_report(report_word_t r);
            report_word_t want;
            if (due_reports.size() == 0)
            begin
                flag_mismatch("report word with none outstanding", r, 0);
                return;
            end
            want = due_reports.pop_front();
            reports_checked++;
            if (r.pwm_duty !== want.pwm_duty)
                flag_mismatch("pwm_duty", r.pwm_duty, want.pwm_duty);
            if (r.speed_rpm !== want.speed_rpm)
                flag_mismatch("speed_rpm", r.speed_rpm, want.speed_rpm);
            if (r.speed_ok !== want.speed_ok)
                flag_mismatch("speed_ok", r.speed_ok, want.speed_ok);
        endtask
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    ssrsg_sample_if sample_ch();
    ssrsg_report_if report_ch();

    spindle_scoreboard sb;

    // idling knobs, set per phase by the stimulus and read by the sender and receiver
    int sender_idle_pct = 0;
    int receiver_stall_pct = 0;
    int hold_asks = 0;          // bumped to request one long report hold-off
    int settings_count = 0;

    spindle_speed_ramp_stall_guard dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .sample_word (sample_ch),
        .report_word (report_ch),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    always
    begin
        #CLK_HALF_NS clk = 1'b1;
        #CLK_HALF_NS clk = 1'b0;
    end

    // watchdog: a hung handshake or lost report ends the run here
    initial
    begin
        #LIMIT_NS;
        $display("testbench: done, errors");
        $finish;
    end

    // both handshakes are observed at the rising edge, where drives have long settled
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (sample_ch.valid && sample_ch.ready)
                sb.note_sample('{sample_ch.tach_rise, sample_ch.gate_end, sample_ch.ms_tick,
                                 sample_ch.set_valid, sample_ch.set_percent});
            if (report_ch.valid && report_ch.ready)
                sb.check_report('{report_ch.pwm_duty, report_ch.speed_rpm,
                                  report_ch.speed_ok});
        end
    end

    // report sink: random stalls, plus a long hold-off whenever one is asked for,
    // counted here so the sender keeps offering words and the pipe backs up
    initial
    begin : report_sink
        int hold_left;
        int hold_seen;
        hold_left       = 0;
        hold_seen       = 0;
        report_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_asks != hold_seen)
            begin
                hold_seen = hold_asks;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                report_ch.ready <= 1'b0;
            end
            else
                report_ch.ready <= ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    function automatic sample_word_t word_of(logic rise, logic gate, logic tick, logic cmd,
                                             logic [PCT_W-1:0] pct);
        return '{rise, gate, tick, cmd, pct};
    endfunction

    // random sample word: commands are rare so the ramp has time to walk down
    function automatic sample_word_t random_word();
        sample_word_t w;
        w.tach_rise = 1'($urandom_range(1));
        w.gate_end  = ($urandom_range(15) == 0);
        w.ms_tick   = 1'($urandom_range(1));
        w.set_valid = ($urandom_range(31) == 0);
        case ($urandom_range(2))
            0: w.set_percent = PCT_W'($urandom_range(255));
            1: w.set_percent = PCT_W'($urandom_range(FULL_PCT));
            default:
                case ($urandom_range(3))
                    0: w.set_percent = '0;
                    1: w.set_percent = PCT_W'(FULL_PCT);
                    2: w.set_percent = PCT_W'(FULL_PCT + 1);
                    default: w.set_percent = '1;
                endcase
        endcase
        return w;
    endfunction

    // offer one word, after a random gap, and wait for it to be taken;
    // entered and left on a falling edge
    task automatic send_word(sample_word_t w);
        int gap;
        gap = 0;
        while ($urandom_range(99) < sender_idle_pct)
            gap++;
        if (gap > 0)
        begin
            sample_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        sample_ch.valid       <= 1'b1;
        sample_ch.tach_rise   <= w.tach_rise;
        sample_ch.gate_end    <= w.gate_end;
        sample_ch.ms_tick     <= w.ms_tick;
        sample_ch.set_valid   <= w.set_valid;
        sample_ch.set_percent <= w.set_percent;
        @(posedge clk);
        while (!sample_ch.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // stop offering, then wait for every outstanding report and the pipe to settle
    task automatic drain();
        sample_ch.valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        sb.set_reg(idx, data);
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // register settings per phase: phases 1 and 2 pin extremes, 3 partly random, rest random
    task automatic apply_settings(int phase);
        logic                  inv;
        logic [PCT_W-1:0]      fs;
        logic [CFG_DATA_W-1:0] rpc;
        logic [CFG_DATA_W-1:0] top;
        case (phase)
            1:
            begin
                inv = 1'b1; fs = 8'd255; rpc = 16'hFFFF; top = 16'hFFFF;
            end
            2:
            begin
                inv = 1'b0; fs = 8'd100; rpc = 16'd1; top = 16'd1;
            end
            3:
            begin
                inv = 1'b1; fs = 8'd100;
                rpc = CFG_DATA_W'($urandom_range(8, 1));
                top = CFG_DATA_W'($urandom_range(65535, 1));
            end
            default:
            begin
                inv = 1'($urandom_range(1));
                fs  = PCT_W'($urandom_range(255, 100));
                rpc = $urandom_range(1) ? CFG_DATA_W'($urandom_range(16, 1))
                                        : CFG_DATA_W'($urandom_range(65535, 1));
                top = CFG_DATA_W'($urandom_range(65535, 1));
            end
        endcase
        write_reg(REG_PWM_INVERT, CFG_DATA_W'(inv));
        write_reg(REG_PWM_FULL_SCALE, CFG_DATA_W'(fs));
        write_reg(REG_RPM_PER_COUNT, rpc);
        write_reg(REG_MAX_RPM, top);
        settings_count++;
    endtask

    initial
    begin
        int i;
        int phase;
        sb                    = new();
        rst_n                 = 1'b0;
        cfg_we                = 1'b0;
        cfg_index             = REG_PWM_INVERT;
        cfg_data              = '0;
        sample_ch.valid       = 1'b0;
        sample_ch.tach_rise   = 1'b0;
        sample_ch.gate_end    = 1'b0;
        sample_ch.ms_tick     = 1'b0;
        sample_ch.set_valid   = 1'b0;
        sample_ch.set_percent = '0;
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        settings_count = 1;

        // directed words on the reset settings
        send_word(word_of(1'b0, 1'b0, 1'b0, 1'b0, 8'd0));     // quiet word
        send_word(word_of(1'b1, 1'b0, 1'b0, 1'b1, 8'd255));   // command above 100 clamps
        send_word(word_of(1'b1, 1'b0, 1'b1, 1'b0, 8'd0));
        send_word(word_of(1'b1, 1'b1, 1'b0, 1'b0, 8'd0));     // edge and gate together
        send_word(word_of(1'b0, 1'b1, 1'b1, 1'b0, 8'd0));     // empty window
        for (i = 0; i < 10; i++)
            send_word(word_of(1'b0, 1'b0, 1'b1, 1'b0, 8'd0)); // ramp step on the eleventh tick
        send_word(word_of(1'b0, 1'b0, 1'b1, 1'b1, 8'd50));    // lower target, replaced before the ramp can step down
        send_word(word_of(1'b0, 1'b0, 1'b1, 1'b1, 8'd101));
        send_word(word_of(1'b1, 1'b1, 1'b1, 1'b1, 8'd0));     // everything in one word
        send_word(word_of(1'b0, 1'b0, 1'b1, 1'b1, 8'd100));
        drain();

        // stall: full target, next to no tach edges, ticks arm the guard and run its timer
        send_word(word_of(1'b0, 1'b0, 1'b1, 1'b1, 8'd100));
        for (i = 0; i < STALL_TICKS; i++)
            send_word(word_of($urandom_range(7) == 0, $urandom_range(63) == 0, 1'b1, 1'b0,
                              8'd0));
        // a fresh command clears the flag, then a few ticks re-arm it
        send_word(word_of(1'b0, 1'b0, 1'b0, 1'b1, 8'd100));
        for (i = 0; i < 5; i++)
            send_word(word_of(1'b0, 1'b0, 1'b1, 1'b0, 8'd0));
        drain();

        // recovery by speed: one edge now reads as the largest 16-bit rpm
        write_reg(REG_RPM_PER_COUNT, 16'hFFFF);
        settings_count++;
        send_word(word_of(1'b1, 1'b1, 1'b1, 1'b0, 8'd0));
        send_word(word_of(1'b0, 1'b0, 1'b1, 1'b0, 8'd0));
        drain();

        // random phases, cycling through the idling mixes
        for (phase = 1; phase <= PHASES; phase++)
        begin
            apply_settings(phase);
            case (phase % 4)
                0:
                begin
                    sender_idle_pct = 0;  receiver_stall_pct = 0;
                end
                1:
                begin
                    sender_idle_pct = 50; receiver_stall_pct = 0;
                end
                2:
                begin
                    sender_idle_pct = 0;  receiver_stall_pct = 50;
                end
                default:
                begin
                    sender_idle_pct = 34; receiver_stall_pct = 34;
                end
            endcase
            for (i = 0; i < PHASE_WORDS; i++)
            begin
                if (i == PHASE_WORDS / 3)
                    hold_asks++;    // back-pressure: the pipe fills and input stalls
                send_word(random_word());
            end
            drain();
        end

        if (sb.pending() != 0)
            sb.flag_mismatch("reports still outstanding at the end", sb.pending(), 0);
        $display("summary: %0d sample words over %0d register settings, %0d reports checked",
                 sb.words_seen, settings_count, sb.reports_checked);
        $display("summary: %0d reports under stall timeout, %0d with clipped rpm, %0d ramp steps",
                 sb.timeout_reports, sb.clipped_reports, sb.ramp_steps);
        if (sb.mismatches == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule

// ----- spindle_speed_ramp_stall_guard.f -----
hdl/ssrsg_pkg.sv
hdl/ssrsg_ifs.sv
hdl/spindle_speed_ramp_stall_guard.sv
test/testbench.sv
